[rtl/iirdf1_pkg.sv]
// shared types, register indexes and sizes for the direct-form-I iir filter
`default_nettype none

package iirdf1_pkg;

   localparam int DATA_W  = 16;
   localparam int COEF_W  = 16;
   localparam int COUNT_W = 2;
   localparam int PROD_W  = DATA_W + COEF_W;
   localparam int ACC_W   = PROD_W + 2;       // five products summed exactly
   localparam int QUO_W   = ACC_W - 1;        // magnitude of the sum
   localparam int DMAG_W  = COEF_W + 1;       // magnitude of the divisor plus compare bit
   localparam int REM_W   = COEF_W;
   localparam int CNT_W   = 6;
   localparam int CSR_IDX_W = 3;

   localparam logic [CNT_W-1:0] MAC_LAST = CNT_W'(5);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_ZERO_TAP = 2'd1;
   localparam logic [1:0] STATUS_ZERO_DIV = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_FF_COEF_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FF_COEF_1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FF_COEF_2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FB_COEF_0 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FB_COEF_1 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FB_COEF_2 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FF_COUNT  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_FB_COUNT  = 3'd7;

   typedef struct packed {
      logic signed [DATA_W-1:0] sample;
      logic                     last_in_block;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] filtered;
      logic [1:0]               status;
      logic                     saturated;
      logic                     block_end;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_PREP,
      ST_DIV,
      ST_FIN
   } state_type;

endpackage

`default_nettype wire

[rtl/iir_direct_form_one_filter.sv]
// direct-form-I iir filter: one shared multiplier, then a bit-serial divider
// sequence per item: multiply-accumulate steps, prep, divide steps, then finish;
// error items go straight from idle to finish; a stalled result holds finish
// a new item is accepted only in idle, so not before the last one has left finish;
// the pace is set by the five taps through the single multiplier and the restoring divider
// reset: synchronous, coefficients to 1.0 / 0, tap counts to 1, history cleared
`default_nettype none

module iir_direct_form_one_filter (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire iirdf1_pkg::req_type                   req_data,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output iirdf1_pkg::rsp_type                        rsp_data,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [iirdf1_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [iirdf1_pkg::COEF_W-1:0]         csr_wdata
);
   import iirdf1_pkg::*;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic signed [COEF_W-1:0] ff_coef_ff [3];
   logic signed [COEF_W-1:0] fb_coef_ff [3];
   logic [COUNT_W-1:0] ff_count_ff, fb_count_ff;

   logic signed [DATA_W-1:0] xh_ff [2];
   logic signed [DATA_W-1:0] yh_ff [2];

   logic signed [DATA_W-1:0] sample_ff, sample_in;
   logic last_ff, last_in;
   logic [1:0] err_ff, err_in;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic sub_ff, sub_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [DMAG_W-1:0] dmag_ff, dmag_in;
   logic neg_ff, neg_in;

   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // sequencer controls
   logic accept, fin_go, out_free;

   // datapath helpers
   logic signed [COEF_W-1:0] mul_a;
   logic signed [DATA_W-1:0] mul_b;
   logic mul_use, mul_sub;
   logic signed [ACC_W-1:0] acc_abs;
   logic [DMAG_W-1:0] shifted;
   logic fit;
   logic signed [DATA_W-1:0] y_val;
   logic y_sat;
   logic update_hist, clear_hist;

   assign out_free  = !(rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (ff_count_ff == '0 || fb_count_ff == '0 || fb_coef_ff[0] == '0) begin
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_MAC;
               end
            end
         end
         ST_MAC:  if (cnt_ff == MAC_LAST) state_in = ST_PREP;
         ST_PREP: state_in = ST_DIV;
         ST_DIV:  if (cnt_ff == DIV_LAST) state_in = ST_FIN;
         ST_FIN:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      fin_go    = 1'b0;
      case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_FIN:  fin_go    = out_free;
         default: begin
            req_stall = 1'b1;
            fin_go    = 1'b0;
         end
      endcase
   end

   // operand select for the shared multiplier
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_use = 1'b0;
      mul_sub = 1'b0;
      case (cnt_ff[2:0])
         3'd0: begin
            mul_a = ff_coef_ff[0]; mul_b = sample_ff; mul_use = 1'b1;
         end
         3'd1: begin
            mul_a = ff_coef_ff[1]; mul_b = xh_ff[0]; mul_use = (ff_count_ff >= 2'd2);
         end
         3'd2: begin
            mul_a = ff_coef_ff[2]; mul_b = xh_ff[1]; mul_use = (ff_count_ff == 2'd3);
         end
         3'd3: begin
            mul_a = fb_coef_ff[1]; mul_b = yh_ff[0]; mul_sub = 1'b1;
            mul_use = (fb_count_ff >= 2'd2);
         end
         3'd4: begin
            mul_a = fb_coef_ff[2]; mul_b = yh_ff[1]; mul_sub = 1'b1;
            mul_use = (fb_count_ff == 2'd3);
         end
         default: mul_use = 1'b0;
      endcase
   end

   // divide step and final saturation
   always_comb begin
      acc_abs = acc_ff[ACC_W-1] ? -acc_ff : acc_ff;
      shifted = {rem_ff, quo_ff[QUO_W-1]};
      fit     = (shifted >= dmag_ff);
      if (neg_ff) begin
         y_sat = (quo_ff > QUO_W'(32768));
         y_val = y_sat ? DATA_W'(-32768) : -$signed(quo_ff[DATA_W-1:0]);
      end else begin
         y_sat = (quo_ff > QUO_W'(32767));
         y_val = y_sat ? DATA_W'(32767) : $signed(quo_ff[DATA_W-1:0]);
      end
   end

   // datapath next values
   always_comb begin
      cnt_in       = cnt_ff;
      sample_in    = sample_ff;
      last_in      = last_ff;
      err_in       = err_ff;
      prod_in      = prod_ff;
      sub_in       = sub_ff;
      acc_in       = acc_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dmag_in      = dmag_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      update_hist  = 1'b0;
      clear_hist   = 1'b0;

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sample_in = req_data.sample;
               last_in   = req_data.last_in_block;
               cnt_in    = '0;
               prod_in   = '0;
               sub_in    = 1'b0;
               acc_in    = '0;
               if (ff_count_ff == '0 || fb_count_ff == '0) begin
                  err_in = STATUS_ZERO_TAP;
               end else if (fb_coef_ff[0] == '0) begin
                  err_in = STATUS_ZERO_DIV;
               end else begin
                  err_in = STATUS_OK;
               end
            end
         end
         ST_MAC: begin
            // product registered in the previous step lands in the sum in this step
            acc_in  = sub_ff ? acc_ff - ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);
            prod_in = mul_use ? PROD_W'(mul_a * mul_b) : '0;
            sub_in  = mul_sub;
            cnt_in  = cnt_ff + 1'b1;
         end
         ST_PREP: begin
            quo_in  = acc_abs[QUO_W-1:0];
            rem_in  = '0;
            neg_in  = acc_ff[ACC_W-1] ^ fb_coef_ff[0][COEF_W-1];
            dmag_in = fb_coef_ff[0][COEF_W-1] ? -DMAG_W'(fb_coef_ff[0])
                                               : DMAG_W'(fb_coef_ff[0]);
            cnt_in  = '0;
         end
         ST_DIV: begin
            rem_in = fit ? REM_W'(shifted - dmag_ff) : shifted[REM_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], fit};
            cnt_in = cnt_ff + 1'b1;
         end
         ST_FIN: begin
            if (fin_go) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.block_end = last_ff;
               rsp_data_in.status    = err_ff;
               if (err_ff != STATUS_OK) begin
                  rsp_data_in.filtered  = '0;
                  rsp_data_in.saturated = 1'b0;
               end else begin
                  rsp_data_in.filtered  = y_val;
                  rsp_data_in.saturated = y_sat;
                  update_hist           = !last_ff;
               end
               clear_hist = last_ff;
            end
         end
         default: cnt_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         ff_coef_ff[0] <= 16'sd16384;
         ff_coef_ff[1] <= '0;
         ff_coef_ff[2] <= '0;
         fb_coef_ff[0] <= 16'sd16384;
         fb_coef_ff[1] <= '0;
         fb_coef_ff[2] <= '0;
         ff_count_ff   <= 2'd1;
         fb_count_ff   <= 2'd1;
         xh_ff[0]      <= '0;
         xh_ff[1]      <= '0;
         yh_ff[0]      <= '0;
         yh_ff[1]      <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_FF_COEF_0: ff_coef_ff[0] <= csr_wdata;
               REG_FF_COEF_1: ff_coef_ff[1] <= csr_wdata;
               REG_FF_COEF_2: ff_coef_ff[2] <= csr_wdata;
               REG_FB_COEF_0: fb_coef_ff[0] <= csr_wdata;
               REG_FB_COEF_1: fb_coef_ff[1] <= csr_wdata;
               REG_FB_COEF_2: fb_coef_ff[2] <= csr_wdata;
               REG_FF_COUNT:  ff_count_ff   <= csr_wdata[COUNT_W-1:0];
               REG_FB_COUNT:  fb_count_ff   <= csr_wdata[COUNT_W-1:0];
               default:       ff_count_ff   <= ff_count_ff;
            endcase
         end
         if (clear_hist) begin
            xh_ff[0] <= '0;
            xh_ff[1] <= '0;
            yh_ff[0] <= '0;
            yh_ff[1] <= '0;
         end else if (update_hist) begin
            xh_ff[1] <= xh_ff[0];
            xh_ff[0] <= sample_ff;
            yh_ff[1] <= yh_ff[0];
            yh_ff[0] <= y_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      last_ff     <= last_in;
      err_ff      <= err_in;
      prod_ff     <= prod_in;
      sub_ff      <= sub_in;
      acc_ff      <= acc_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      dmag_ff     <= dmag_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire
